[design/sasu_pkg.sv]
// package: shared constants and controller/datapath command and status types
`default_nettype none
package sasu_pkg;
	localparam int VERTEX_W = 6;
	localparam int NUM_VALUES = 1 << VERTEX_W;
	localparam int DEF_NUM_VERTICES = 64;
	localparam int DEF_MAX_DEGREE = 64;

	typedef struct packed {
		logic idle;
		logic latch_du;
		logic deg_sel_v;
		logic latch_dv;
		logic edge_wr1;
		logic edge_wr2;
		logic set_fail;
		logic tally_clr;
		logic load_d;
		logic latch_val;
		logic tally_wr;
		logic scan_init;
		logic scan_rd;
		logic get_cnt;
		logic j_inc;
		logic emit_status;
		logic emit_empty;
		logic emit_nbr;
	} cmd_t;

	typedef struct packed {
		logic accept;
		logic acc_list;
		logic fail;
		logic d_zero;
		logic i_last;
		logic c_zero;
		logic k_last;
		logic rem_one;
		logic slot_free;
	} sts_t;
endpackage
`default_nettype wire

[design/sasu_if.sv]
// interfaces: input transaction channel and result channel
`default_nettype none
interface sasu_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [5:0] first_vertex;
	logic [5:0] second_vertex;
	modport source (output valid, opcode, first_vertex, second_vertex, input ready);
	modport sink (input valid, opcode, first_vertex, second_vertex, output ready);
endinterface

interface sasu_out_if;
	logic       valid;
	logic       ready;
	logic [5:0] neighbor;
	logic       last;
	logic       empty_res;
	logic       status;
	modport source (output valid, neighbor, last, empty_res, status, input ready);
	modport sink (input valid, neighbor, last, empty_res, status, output ready);
endinterface
`default_nettype wire

[design/sasu_ram.sv]
// generic single write port ram with registered read
`default_nettype none
module sasu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[design/sasu_ctrl.sv]
// controller state machine for edge insertion and sorted list readout
`default_nettype none
module sasu_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire sasu_pkg::sts_t sts,
	output sasu_pkg::cmd_t     cmd
);
	import sasu_pkg::*;

	typedef enum logic [3:0] {
		IDLE, E_U, E_V, E_CHK, E_W2, EMIT_ST, L_RD, L_D, L_SR, L_TR, L_TW,
		S_RD, S_GET, S_EMIT, EMIT_EMPTY
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			IDLE: begin
				cmd.idle = 1'b1;
				if (sts.accept) begin
					state_d = sts.acc_list ? L_RD : E_U;
				end
			end
			E_U: state_d = E_V;
			E_V: begin
				cmd.latch_du = 1'b1;
				cmd.deg_sel_v = 1'b1;
				state_d = E_CHK;
			end
			E_CHK: begin
				cmd.set_fail = 1'b1;
				if (sts.fail) begin
					state_d = EMIT_ST;
				end else begin
					cmd.edge_wr1 = 1'b1;
					cmd.latch_dv = 1'b1;
					state_d = E_W2;
				end
			end
			E_W2: begin
				cmd.edge_wr2 = 1'b1;
				state_d = EMIT_ST;
			end
			EMIT_ST: begin
				if (sts.slot_free) begin
					cmd.emit_status = 1'b1;
					state_d = IDLE;
				end
			end
			L_RD: begin
				cmd.tally_clr = 1'b1;
				state_d = L_D;
			end
			L_D: begin
				cmd.load_d = 1'b1;
				state_d = sts.d_zero ? EMIT_EMPTY : L_SR;
			end
			L_SR: state_d = L_TR;
			L_TR: begin
				cmd.latch_val = 1'b1;
				state_d = L_TW;
			end
			L_TW: begin
				cmd.tally_wr = 1'b1;
				if (sts.i_last) begin
					cmd.scan_init = 1'b1;
					state_d = S_RD;
				end else begin
					state_d = L_SR;
				end
			end
			S_RD: begin
				cmd.scan_rd = 1'b1;
				state_d = S_GET;
			end
			S_GET: begin
				cmd.get_cnt = 1'b1;
				if (sts.c_zero) begin
					cmd.j_inc = 1'b1;
					state_d = S_RD;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.slot_free) begin
					cmd.emit_nbr = 1'b1;
					if (sts.k_last) begin
						state_d = IDLE;
					end else if (sts.rem_one) begin
						cmd.j_inc = 1'b1;
						state_d = S_RD;
					end
				end
			end
			EMIT_EMPTY: begin
				if (sts.slot_free) begin
					cmd.emit_empty = 1'b1;
					state_d = IDLE;
				end
			end
			default: state_d = IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

[design/sasu_dp.sv]
// datapath: degree and neighbor memories, counting sort tally, output register
`default_nettype none
module sasu_dp #(
	parameter int NUM_VERTICES = sasu_pkg::DEF_NUM_VERTICES,
	parameter int MAX_DEGREE = sasu_pkg::DEF_MAX_DEGREE
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire sasu_pkg::cmd_t cmd,
	output sasu_pkg::sts_t      sts,
	sasu_in_if.sink             in_ch,
	sasu_out_if.source          out_ch
);
	import sasu_pkg::*;

	localparam int NV_EFF = (NUM_VERTICES < NUM_VALUES) ? NUM_VERTICES : NUM_VALUES;
	localparam int VIW = $clog2(NV_EFF);
	localparam int DW = $clog2(MAX_DEGREE + 1);
	localparam int SDEPTH = NV_EFF * MAX_DEGREE;
	localparam int SAW = $clog2(SDEPTH);
	localparam int TW = $clog2(NUM_VALUES + 1);

	logic                opcode_q;
	logic [VERTEX_W-1:0] a_q, b_q, val_q, j_q;
	logic [DW-1:0]       du_q, dv_q, d_q, i_q, k_q, rem_q;
	logic                fail_q;
	logic                fail_c;
	logic                a_ok, b_ok, self_loop;
	logic [VIW-1:0]      a_idx, b_idx;
	logic [SAW-1:0]      base_a, base_b;

	logic [NV_EFF-1:0]   dvalid_q;
	logic                dvld_q;
	logic [VIW-1:0]      deg_raddr, deg_waddr;
	logic [DW-1:0]       deg_rdata, deg_wdata, deg_val;
	logic                deg_we;

	logic [SAW-1:0]      st_waddr, st_raddr;
	logic [VERTEX_W-1:0] st_wdata, st_rdata;
	logic                st_we;

	logic [NUM_VALUES-1:0] tvalid_q;
	logic                  tvld_q;
	logic [VERTEX_W-1:0]   t_raddr;
	logic [TW-1:0]         t_rdata, t_val;

	logic                out_valid_q;
	logic [VERTEX_W-1:0] nb_q;
	logic                last_q, empty_q, status_q;

	assign a_ok = 32'(a_q) < NUM_VERTICES;
	assign b_ok = 32'(b_q) < NUM_VERTICES;
	assign self_loop = a_q == b_q;
	assign a_idx = a_q[VIW-1:0];
	assign b_idx = b_q[VIW-1:0];
	assign base_a = SAW'(a_idx) * SAW'(MAX_DEGREE);
	assign base_b = SAW'(b_idx) * SAW'(MAX_DEGREE);

	// degree memory
	assign deg_raddr = cmd.deg_sel_v ? b_idx : a_idx;
	assign deg_val = dvld_q ? deg_rdata : '0;
	assign deg_we = cmd.edge_wr1 || cmd.edge_wr2;
	assign deg_waddr = cmd.edge_wr2 ? b_idx : a_idx;
	always_comb begin
		if (cmd.edge_wr2) begin
			deg_wdata = self_loop ? DW'(du_q + DW'(2)) : DW'(dv_q + DW'(1));
		end else begin
			deg_wdata = DW'(du_q + DW'(1));
		end
	end

	sasu_ram #(.WIDTH(DW), .DEPTH(NV_EFF)) u_deg_ram (
		.clk(clk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
		.raddr(deg_raddr), .rdata(deg_rdata)
	);

	// neighbor memory
	assign st_we = cmd.edge_wr1 || cmd.edge_wr2;
	always_comb begin
		if (cmd.edge_wr2) begin
			st_waddr = base_b + SAW'(self_loop ? DW'(du_q + DW'(1)) : dv_q);
			st_wdata = a_q;
		end else begin
			st_waddr = base_a + SAW'(du_q);
			st_wdata = b_q;
		end
	end
	assign st_raddr = base_a + SAW'(i_q);

	sasu_ram #(.WIDTH(VERTEX_W), .DEPTH(SDEPTH)) u_store_ram (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
		.raddr(st_raddr), .rdata(st_rdata)
	);

	// counting sort tally
	assign t_raddr = cmd.scan_rd ? j_q : st_rdata;
	assign t_val = tvld_q ? t_rdata : '0;

	sasu_ram #(.WIDTH(TW), .DEPTH(NUM_VALUES)) u_tally_ram (
		.clk(clk), .we(cmd.tally_wr), .waddr(val_q), .wdata(TW'(t_val + TW'(1))),
		.raddr(t_raddr), .rdata(t_rdata)
	);

	// status
	always_comb begin
		if (!a_ok || !b_ok) begin
			fail_c = 1'b1;
		end else if (self_loop) begin
			fail_c = ({1'b0, du_q} + (DW+1)'(2)) > (DW+1)'(MAX_DEGREE);
		end else begin
			fail_c = (du_q >= DW'(MAX_DEGREE)) || (deg_val >= DW'(MAX_DEGREE));
		end
	end
	assign sts.accept = in_ch.valid && in_ch.ready;
	assign sts.acc_list = in_ch.opcode;
	assign sts.fail = fail_c;
	assign sts.d_zero = !a_ok || (deg_val == '0);
	assign sts.i_last = i_q == DW'(d_q - DW'(1));
	assign sts.c_zero = t_val == '0;
	assign sts.k_last = k_q == DW'(d_q - DW'(1));
	assign sts.rem_one = rem_q == DW'(1);
	assign sts.slot_free = !out_valid_q || out_ch.ready;

	assign in_ch.ready = cmd.idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvalid_q <= '0;
			tvalid_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (deg_we) begin
				dvalid_q[deg_waddr] <= 1'b1;
			end
			if (cmd.tally_clr) begin
				tvalid_q <= '0;
			end else if (cmd.tally_wr) begin
				tvalid_q[val_q] <= 1'b1;
			end
			if (cmd.emit_status || cmd.emit_empty || cmd.emit_nbr) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		dvld_q <= dvalid_q[deg_raddr];
		tvld_q <= tvalid_q[t_raddr];
		if (sts.accept) begin
			opcode_q <= in_ch.opcode;
			a_q <= in_ch.first_vertex;
			b_q <= in_ch.second_vertex;
		end
		if (cmd.latch_du) begin
			du_q <= deg_val;
		end
		if (cmd.latch_dv) begin
			dv_q <= deg_val;
		end
		if (cmd.set_fail) begin
			fail_q <= fail_c;
		end
		if (cmd.load_d) begin
			d_q <= a_ok ? deg_val : '0;
			i_q <= '0;
			k_q <= '0;
		end else if (cmd.tally_wr) begin
			i_q <= DW'(i_q + DW'(1));
		end else if (cmd.emit_nbr) begin
			k_q <= DW'(k_q + DW'(1));
		end
		if (cmd.latch_val) begin
			val_q <= st_rdata;
		end
		if (cmd.scan_init) begin
			j_q <= '0;
		end else if (cmd.j_inc) begin
			j_q <= VERTEX_W'(j_q + VERTEX_W'(1));
		end
		if (cmd.get_cnt) begin
			rem_q <= DW'(t_val);
		end else if (cmd.emit_nbr) begin
			rem_q <= DW'(rem_q - DW'(1));
		end
		if (cmd.emit_status) begin
			nb_q <= '0;
			last_q <= 1'b1;
			empty_q <= 1'b0;
			status_q <= fail_q;
		end else if (cmd.emit_empty) begin
			nb_q <= '0;
			last_q <= 1'b1;
			empty_q <= 1'b1;
			status_q <= 1'b0;
		end else if (cmd.emit_nbr) begin
			nb_q <= j_q;
			last_q <= sts.k_last;
			empty_q <= 1'b0;
			status_q <= 1'b0;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.neighbor = nb_q;
	assign out_ch.last = last_q;
	assign out_ch.empty_res = empty_q;
	assign out_ch.status = status_q;

	a_deg_bound: assert property (@(posedge clk) disable iff (!arst_n)
		deg_we |-> deg_wdata <= DW'(MAX_DEGREE))
		else $error("degree exceeds bound");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_status || cmd.emit_empty || cmd.emit_nbr) |-> sts.slot_free)
		else $error("result register overwritten");
	a_tally_list: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tally_wr |-> opcode_q && a_ok)
		else $error("tally written outside a list transaction");
	a_edge_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.edge_wr1 |=> cmd.edge_wr2)
		else $error("edge insertion incomplete");
endmodule
`default_nettype wire

[design/sorted_adjacency_list_store_unit.sv]
// top level: sorted adjacency list store, controller plus datapath
// in_ch carries transactions (opcode, first_vertex, second_vertex) under
// valid/ready; out_ch carries results (neighbor, last, empty_res, status).
// an add-edge transaction loads its status result in EMIT_ST after the
// states E_U, E_V, E_CHK and E_W2, with E_W2 skipped when the range or
// fullness check drops it; a list transaction gives one empty result
// after L_RD and L_D, or d results in ascending order, produced by the
// read-modify-write of the tally memory per stored neighbor (L_SR, L_TR,
// L_TW), the scan of up to 64 counters (S_RD, S_GET) and S_EMIT per result.
// one transaction is worked on at a time; in_ch.ready is high only while
// the controller waits for work, also while a result still sits in the
// output register.
// reset clears the degree and tally valid bits at once, so every list
// starts empty; no clearing pass is needed.
// a stalled receiver holds the output register and the controller waits
// before producing the next result.
`default_nettype none
module sorted_adjacency_list_store_unit #(
	parameter int NUM_VERTICES = sasu_pkg::DEF_NUM_VERTICES,
	parameter int MAX_DEGREE = sasu_pkg::DEF_MAX_DEGREE
) (
	input wire logic   clk,
	input wire logic   arst_n,
	sasu_in_if.sink    in_ch,
	sasu_out_if.source out_ch
);
	import sasu_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sasu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .sts(sts), .cmd(cmd)
	);

	sasu_dp #(.NUM_VERTICES(NUM_VERTICES), .MAX_DEGREE(MAX_DEGREE)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_ch(in_ch), .out_ch(out_ch)
	);
endmodule
`default_nettype wire
